// ----- hdl/csfq_pkg.sv -----
// ============================================================================
// Credit shaper flow queues package
// Shared types, constants and control structures of the flow queue shaper.
// ============================================================================
`default_nettype none

package csfq_pkg;

  // Default sizes.
  localparam int NUM_FLOWS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 64;

  // Flow classification.
  localparam logic [15:0] PORT_LIMIT   = 16'd30000;
  localparam logic [14:0] DEFAULT_FLOW = 15'd1001;

  // Register reset values.
  localparam logic [7:0]  ALPHA_RST  = 8'd14;
  localparam logic [23:0] BUFFER_RST = 24'd1048576;
  localparam logic [19:0] RATE_RST   = 20'd10;

  // Saturation limits.
  localparam logic [25:0]        QB_MAX     = 26'h3FF_FFFF;
  localparam logic signed [39:0] CREDIT_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] CREDIT_MIN = 40'sh80_0000_0000;

  // Result status codes.
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_DEQUEUED = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_BUFFER = 2'd1;
  localparam logic [1:0] REG_RATE   = 2'd2;

  // Command codes.
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] pkt_bytes;
    logic [15:0] packet_handle;
    logic [31:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] flow_id;
    logic [15:0] out_handle;
    logic [15:0] out_size;
    logic [25:0] queued_total;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [23:0] data;
  } cfg_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic setup;
    logic scan;
    logic pick;
    logic enq;
    logic rd;
    logic deq;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic is_deq;
    logic scan_last;
    logic found;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- hdl/csfq_if.sv -----
// ============================================================================
// Credit shaper flow queues channels
// Valid/ready channels for input items, result items and register writes.
// ============================================================================
`default_nettype none

interface csfq_in_if;
  logic              valid;
  logic              ready;
  csfq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csfq_out_if;
  logic               valid;
  logic               ready;
  csfq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csfq_cfg_if;
  logic               valid;
  logic               ready;
  csfq_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/csfq_ctrl.sv -----
// ============================================================================
// Credit shaper controller
// State machine that sequences the flow table scan and queue operations.
// ============================================================================
`default_nettype none

module csfq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire csfq_pkg::ctrl_sts_t sts,
  output csfq_pkg::ctrl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_ENQ   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_DEQ   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        if (!sts.found) state_next = S_OUT;
        else if (sts.is_deq) state_next = S_READ;
        else state_next = S_ENQ;
      end
      S_ENQ: begin
        cmd.enq    = 1'b1;
        state_next = S_OUT;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DEQ;
      end
      S_DEQ: begin
        cmd.deq    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Scan always completes before a decision is made.
  a_pick_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> ($past(state) == S_SCAN))
    else $error("pick without completed scan");

  // Only one item is in flight: ready is low until the result is emitted.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.in_ready && sts.in_valid) |=> !cmd.in_ready)
    else $error("second item accepted while busy");

  // A result is emitted only when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("emit into occupied output register");

endmodule

`default_nettype wire

// ----- hdl/csfq_datapath.sv -----
// ============================================================================
// Credit shaper datapath
// Flow table, packet store, admission threshold, credit update and results.
// ============================================================================
`default_nettype none

module csfq_datapath #(
  parameter int NUM_FLOWS  = csfq_pkg::NUM_FLOWS_DEF,
  parameter int FIFO_DEPTH = csfq_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  csfq_in_if.sink                  pkt_in,
  csfq_out_if.source               res_out,
  csfq_cfg_if.sink                 cfg,
  input  wire csfq_pkg::ctrl_cmd_t cmd,
  output csfq_pkg::ctrl_sts_t      sts
);

  localparam int SW    = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int PW    = $clog2(FIFO_DEPTH);
  localparam int CW    = $clog2(FIFO_DEPTH + 1);
  localparam int DEPTH = NUM_FLOWS * FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [7:0]  alpha;
  logic [23:0] buffer_bytes;
  logic [19:0] credit_rate;

  // Flow table.
  logic                 slot_valid  [NUM_FLOWS];
  logic [14:0]          slot_key    [NUM_FLOWS];
  logic signed [39:0]   slot_credit [NUM_FLOWS];
  logic [CW-1:0]        slot_count  [NUM_FLOWS];
  logic [PW-1:0]        slot_head   [NUM_FLOWS];
  logic [PW-1:0]        slot_tail   [NUM_FLOWS];

  // Packet store.
  logic [31:0] packet_store [DEPTH];
  logic [31:0] rd_word;

  // Global state.
  logic [25:0] queued_bytes;
  logic [31:0] last_time;

  // Latched item and work registers.
  csfq_pkg::in_item_t item;
  logic [14:0]        fid;
  logic [SW-1:0]      idx;
  logic signed [35:0] thr;
  logic [51:0]        gain;
  logic               hit;
  logic [SW-1:0]      hit_idx;
  logic               free_found;
  logic [SW-1:0]      free_idx;
  logic               best_found;
  logic [SW-1:0]      best_idx;
  logic [14:0]        best_key;
  csfq_pkg::out_item_t res;

  // Combinational helpers.
  logic [14:0]        fid_calc;
  logic [31:0]        elapsed;
  logic signed [53:0] gain_sum;
  logic signed [39:0] credit_gained;
  logic signed [40:0] credit_diff;
  logic signed [39:0] credit_charged;
  logic [15:0]        rd_size;
  logic [15:0]        rd_handle;
  logic [26:0]        qb_add;
  logic [25:0]        qb_enq;
  logic [25:0]        qb_deq;
  logic               admit;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               elig;

  // Flow id from the transport ports.
  always_comb begin
    if (pkt_in.data.src_port < csfq_pkg::PORT_LIMIT) fid_calc = pkt_in.data.src_port[14:0];
    else if (pkt_in.data.dst_port < csfq_pkg::PORT_LIMIT) fid_calc = pkt_in.data.dst_port[14:0];
    else fid_calc = csfq_pkg::DEFAULT_FLOW;
  end

  // Credit arithmetic with saturation.
  always_comb begin
    elapsed  = item.now_ticks - last_time;
    gain_sum = 54'(slot_credit[idx]) + $signed({2'b00, gain});
    if (gain_sum > 54'(csfq_pkg::CREDIT_MAX)) credit_gained = csfq_pkg::CREDIT_MAX;
    else if (gain_sum < 54'(csfq_pkg::CREDIT_MIN)) credit_gained = csfq_pkg::CREDIT_MIN;
    else credit_gained = gain_sum[39:0];
    rd_size     = rd_word[15:0];
    rd_handle   = rd_word[31:16];
    credit_diff = 41'(slot_credit[idx]) - $signed({25'd0, rd_size});
    if (credit_diff < 41'(csfq_pkg::CREDIT_MIN)) credit_charged = csfq_pkg::CREDIT_MIN;
    else credit_charged = credit_diff[39:0];
    elig = slot_valid[idx] && (slot_count[idx] != '0) && !credit_gained[39];
  end

  // Admission and addressing.
  always_comb begin
    qb_add  = {1'b0, queued_bytes} + {11'd0, item.pkt_bytes};
    qb_enq  = qb_add[26] ? csfq_pkg::QB_MAX : qb_add[25:0];
    qb_deq  = (queued_bytes >= {10'd0, rd_size}) ? queued_bytes - {10'd0, rd_size} : '0;
    admit   = ($signed({10'd0, queued_bytes}) <= thr) &&
              (slot_count[idx] < CW'(FIFO_DEPTH));
    wr_addr = AW'(AW'(idx) * AW'(FIFO_DEPTH)) + AW'(slot_tail[idx]);
    rd_addr = AW'(AW'(idx) * AW'(FIFO_DEPTH)) + AW'(slot_head[idx]);
  end

  // Configuration writes.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= csfq_pkg::ALPHA_RST;
      buffer_bytes <= csfq_pkg::BUFFER_RST;
      credit_rate  <= csfq_pkg::RATE_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        csfq_pkg::REG_ALPHA:  alpha        <= cfg.data.data[7:0];
        csfq_pkg::REG_BUFFER: buffer_bytes <= cfg.data.data;
        csfq_pkg::REG_RATE:   credit_rate  <= cfg.data.data[19:0];
        default: ;
      endcase
    end
  end

  // Admission threshold, kept current from the queued byte count.
  always_ff @(posedge clk) begin
    thr <= $signed({1'b0, alpha}) *
           ($signed({3'b000, buffer_bytes}) - $signed({1'b0, queued_bytes}));
  end

  // Item latch and credit gain.
  always_ff @(posedge clk) begin
    if (cmd.in_ready && pkt_in.valid) begin
      item <= pkt_in.data;
      fid  <= fid_calc;
    end
    if (cmd.setup) begin
      // Elapsed time wraps at 32 bits before it is scaled by the rate.
      gain <= 52'(elapsed) * 52'(credit_rate);
    end
  end

  // Packet store write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.enq && admit) packet_store[wr_addr] <= {item.packet_handle, item.pkt_bytes};
    if (cmd.rd) rd_word <= packet_store[rd_addr];
  end

  // Flow table, scan and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FLOWS; i++) begin
        slot_valid[i]  <= 1'b0;
        slot_key[i]    <= '0;
        slot_credit[i] <= '0;
        slot_count[i]  <= '0;
        slot_head[i]   <= '0;
        slot_tail[i]   <= '0;
      end
      queued_bytes <= '0;
      last_time    <= '0;
      idx          <= '0;
      hit          <= 1'b0;
      free_found   <= 1'b0;
      best_found   <= 1'b0;
    end else begin
      if (cmd.setup) begin
        idx        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
        if (item.command == csfq_pkg::CMD_DEQUEUE) last_time <= item.now_ticks;
      end
      // One slot per cycle.
      if (cmd.scan) begin
        if (item.command == csfq_pkg::CMD_DEQUEUE) begin
          if (slot_valid[idx]) slot_credit[idx] <= credit_gained;
          if (elig && (!best_found || slot_key[idx] < best_key)) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best_key   <= slot_key[idx];
          end
        end else if (slot_valid[idx]) begin
          if (!hit && slot_key[idx] == fid) begin
            hit     <= 1'b1;
            hit_idx <= idx;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        if (idx != SW'(NUM_FLOWS - 1)) idx <= idx + 1'b1;
      end
      // Choose the slot to work on.
      if (cmd.pick) begin
        res.out_handle   <= '0;
        res.out_size     <= '0;
        res.queued_total <= queued_bytes;
        if (item.command == csfq_pkg::CMD_DEQUEUE) begin
          if (best_found) idx <= best_idx;
          res.status  <= csfq_pkg::ST_NONE;
          res.flow_id <= '0;
        end else begin
          res.status  <= csfq_pkg::ST_DROPPED;
          res.flow_id <= fid;
          if (hit) begin
            idx <= hit_idx;
          end else if (free_found) begin
            idx                     <= free_idx;
            slot_valid[free_idx]  <= 1'b1;
            slot_key[free_idx]    <= fid;
            slot_credit[free_idx] <= '0;
            slot_count[free_idx]  <= '0;
            slot_head[free_idx]   <= '0;
            slot_tail[free_idx]   <= '0;
          end
        end
      end
      // Enqueue commit.
      if (cmd.enq && admit) begin
        slot_tail[idx]  <= (slot_tail[idx] == PW'(FIFO_DEPTH - 1)) ? '0 : slot_tail[idx] + 1'b1;
        slot_count[idx] <= slot_count[idx] + 1'b1;
        queued_bytes    <= qb_enq;
        res.status       <= csfq_pkg::ST_ENQUEUED;
        res.queued_total <= qb_enq;
      end
      // Dequeue commit.
      if (cmd.deq) begin
        slot_head[idx]   <= (slot_head[idx] == PW'(FIFO_DEPTH - 1)) ? '0 : slot_head[idx] + 1'b1;
        slot_count[idx]  <= slot_count[idx] - 1'b1;
        queued_bytes     <= qb_deq;
        slot_credit[idx] <= (slot_count[idx] == CW'(1)) ? '0 : credit_charged;
        res.status       <= csfq_pkg::ST_DEQUEUED;
        res.flow_id      <= slot_key[idx];
        res.out_handle   <= rd_handle;
        res.out_size     <= rd_size;
        res.queued_total <= qb_deq;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (cmd.emit) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
    if (cmd.emit) begin
      res_out.data <= res;
    end
  end

  // Status to the controller.
  always_comb begin
    pkt_in.ready  = cmd.in_ready;
    sts.in_valid  = pkt_in.valid;
    sts.is_deq    = item.command;
    sts.scan_last = (idx == SW'(NUM_FLOWS - 1));
    sts.found     = (item.command == csfq_pkg::CMD_DEQUEUE) ? best_found : (hit || free_found);
    sts.out_free  = !res_out.valid || res_out.ready;
  end

  // A flow's count never exceeds its queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count[idx] <= CW'(FIFO_DEPTH))
    else $error("flow count above queue depth");

  // A flow that empties on dequeue has its credit cleared.
  a_empty_credit: assert property (@(posedge clk) disable iff (rst)
    (cmd.deq && slot_count[idx] == CW'(1)) |=> (slot_credit[$past(idx)] == '0))
    else $error("credit not cleared on empty flow");

  // An emitted result shows on the output in the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> res_out.valid)
    else $error("emitted result not valid");

endmodule

`default_nettype wire

// ----- hdl/credit_shaper_flow_queues.sv -----
// Per-flow credit shaper. An item takes a setup step, a scan of the flow table
// at one flow slot per cycle, and the steps to pick a slot, read the packet
// store and commit. One item is in work at a time; its result waits in an
// output register, and the next item is accepted as soon as that result has
// been handed to it.
// ============================================================================
// Credit shaper flow queues
// Top level: per-flow packet queues with shared-buffer admission and credit.
// ============================================================================
`default_nettype none

module credit_shaper_flow_queues #(
  parameter int NUM_FLOWS  = csfq_pkg::NUM_FLOWS_DEF,
  parameter int FIFO_DEPTH = csfq_pkg::FIFO_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  csfq_in_if.sink    pkt_in,
  csfq_out_if.source res_out,
  csfq_cfg_if.sink   cfg
);

  csfq_pkg::ctrl_cmd_t cmd;
  csfq_pkg::ctrl_sts_t sts;

  // Sequencer.
  csfq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Flow table, packet store and arithmetic.
  csfq_datapath #(
    .NUM_FLOWS  (NUM_FLOWS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_in),
    .res_out (res_out),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

`default_nettype wire
